// ===== rtl/core/gpmtz_pkg.sv =====
// Shared types and constants of the grid path trailing zero block.
`timescale 1ns / 1ps

package gpmtz_pkg;

    // Largest supported grid edge and derived counter width
    localparam int MAX_SIZE = 1024;
    localparam int CNT_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    // Field widths
    localparam int CFG_W   = 11;
    localparam int CELL_W  = 31;
    localparam int SUM_W   = 16;
    localparam int COUNT_W = 5;   // up to 30 twos or 13 fives in a 31-bit value
    localparam int RAM_W   = 2 * SUM_W;

    // Sum codes
    localparam logic [SUM_W-1:0] UNREACH = 16'hFFFF;
    localparam logic [SUM_W-1:0] SUM_MAX = 16'hFFFE;

    // Divisibility by five: w * INV5 mod 2^32 <= LIM5 exactly when 5 divides w,
    // and the product is then w / 5
    localparam logic [31:0] INV5 = 32'hCCCC_CCCD;
    localparam logic [31:0] LIM5 = 32'h3333_3333;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TWOS,
        ST_FIVES,
        ST_UPDATE
    } t_state;

    // Factor unit mode
    typedef enum logic {
        FM_TWO,
        FM_FIVE
    } t_fmode;

    // Command to the factor unit
    typedef struct packed {
        logic   start;
        t_fmode mode;
    } t_factor_cmd;

    // Status from the factor unit
    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
    } t_factor_stat;

endpackage

// ===== rtl/core/gpmtz_if.sv =====
// Valid/ready channel interfaces for cell words and result words.
`timescale 1ns / 1ps

interface gpmtz_in_if;
    logic                            valid;
    logic                            ready;
    logic [gpmtz_pkg::CELL_W-1:0]    cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface gpmtz_out_if;
    logic                            valid;
    logic                            ready;
    logic [gpmtz_pkg::SUM_W-1:0]     min_zeros;
    logic                            no_path;

    modport source (output valid, output min_zeros, output no_path, input ready);
    modport sink   (input valid, input min_zeros, input no_path, output ready);
endinterface

// ===== rtl/core/gpmtz_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module gpmtz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/gpmtz_factor.sv =====
// Iterative factor counter: strips factors of two or of five, one step a cycle.
`timescale 1ns / 1ps

module gpmtz_factor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gpmtz_pkg::t_factor_cmd         i_cmd,
    input  logic [gpmtz_pkg::CELL_W-1:0]   i_value,
    output gpmtz_pkg::t_factor_stat        o_stat
);

    logic                              r_busy;
    logic                              r_done;
    gpmtz_pkg::t_fmode                 r_mode;
    logic [gpmtz_pkg::CELL_W-1:0]      r_work;
    logic [gpmtz_pkg::COUNT_W-1:0]     r_count;

    logic                              n_busy;
    logic                              n_done;
    logic [gpmtz_pkg::CELL_W-1:0]      n_work;
    logic [gpmtz_pkg::COUNT_W-1:0]     n_count;

    logic [3:0]                        nib;
    logic [1:0]                        nib_tz;
    logic [31:0]                       prod5;

    // Trailing zeros of a nonzero nibble
    function automatic logic [1:0] tz_nib(input logic [3:0] v);
        logic [1:0] z;
        priority if (v[0]) z = 2'd0;
        else if (v[1])     z = 2'd1;
        else if (v[2])     z = 2'd2;
        else               z = 2'd3;
        return z;
    endfunction

    assign nib    = r_work[3:0];
    assign nib_tz = tz_nib(nib);
    assign prod5  = 32'({1'b0, r_work} * gpmtz_pkg::INV5);

    // One step of the shared unit
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_work  = r_work;
        n_count = r_count;
        if (r_busy) begin
            unique case (r_mode)
                gpmtz_pkg::FM_TWO: begin
                    if (r_work == '0) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else if (nib == 4'd0) begin
                        n_work  = r_work >> 4;
                        n_count = r_count + gpmtz_pkg::COUNT_W'(4);
                    end else begin
                        n_work  = r_work >> nib_tz;
                        n_count = r_count + gpmtz_pkg::COUNT_W'(nib_tz);
                        n_busy  = 1'b0;
                        n_done  = 1'b1;
                    end
                end
                gpmtz_pkg::FM_FIVE: begin
                    if (r_work != '0 && prod5 <= gpmtz_pkg::LIM5) begin
                        n_work  = prod5[gpmtz_pkg::CELL_W-1:0];
                        n_count = r_count + gpmtz_pkg::COUNT_W'(1);
                    end else begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_mode <= gpmtz_pkg::FM_TWO;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_mode <= i_cmd.mode;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Work value and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work  <= '0;
            r_count <= '0;
        end else if (i_cmd.start) begin
            r_work  <= i_value;
            r_count <= '0;
        end else begin
            r_work  <= n_work;
            r_count <= n_count;
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.count = r_count;

endmodule

// ===== rtl/core/grid_path_min_trailing_zeros.sv =====
// Top level: sequencer, row buffer and result register of the path block.
`timescale 1ns / 1ps

// Takes an N by N grid of cells in row-major order, one cell word per input
// handshake, and after the last cell gives one result word: the least number
// of trailing zeros of a cell product over all right/down paths from the
// top-left to the bottom-right cell, or no_path when zero cells block every
// path. grid_size is to be written through i_cfg_we/i_cfg_data only while the
// block is idle; the block itself does not enforce this. A write restarts the
// grid at the top-left cell (zero reads as 1, values above 1024 as 1024). A
// nonzero cell passes through the accept, one factor unit step per four
// trailing zero bits plus a final step, a hand-off, one step per factor of
// five plus a final test, a hand-off, then the row-buffer update. A zero cell
// goes from the accept straight to the update. The row buffer is one RAM
// holding both sums per column and needs no clearing after reset. A new cell
// is accepted while a result word still waits at the output; the last cell of
// the next grid then holds in its update state until that word is taken.
module grid_path_min_trailing_zeros (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gpmtz_in_if.sink                      i_in,
    gpmtz_out_if.source                   o_out,
    input  logic                          i_cfg_we,
    input  logic [gpmtz_pkg::CFG_W-1:0]   i_cfg_data
);

    gpmtz_pkg::t_state                 r_state;
    gpmtz_pkg::t_state                 n_state;

    logic [gpmtz_pkg::CFG_W-1:0]       r_grid_size;
    logic [gpmtz_pkg::CNT_W-1:0]       r_row;
    logic [gpmtz_pkg::CNT_W-1:0]       r_col;
    logic [gpmtz_pkg::SUM_W-1:0]       r_left2;
    logic [gpmtz_pkg::SUM_W-1:0]       r_left5;
    logic [gpmtz_pkg::CELL_W-1:0]      r_value;
    logic [gpmtz_pkg::COUNT_W-1:0]     r_own2;
    logic [gpmtz_pkg::COUNT_W-1:0]     r_own5;
    logic                              r_out_valid;
    logic [gpmtz_pkg::SUM_W-1:0]       r_min_zeros;
    logic                              r_no_path;

    logic                              in_acc;
    logic                              upd_go;
    logic                              is_last;
    logic                              last_col;
    logic [gpmtz_pkg::CNT_W-1:0]       n_last;

    gpmtz_pkg::t_factor_cmd            f_cmd;
    gpmtz_pkg::t_factor_stat           f_stat;

    logic                              ram_re;
    logic [gpmtz_pkg::RAM_W-1:0]       ram_rdata;
    logic [gpmtz_pkg::RAM_W-1:0]       ram_wdata;

    logic [gpmtz_pkg::SUM_W-1:0]       u2, u5, b2, b5, t2, t5, own2, own5;
    logic [gpmtz_pkg::SUM_W:0]         s2, s5;

    function automatic logic [gpmtz_pkg::SUM_W-1:0] min16(
        input logic [gpmtz_pkg::SUM_W-1:0] a,
        input logic [gpmtz_pkg::SUM_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    // Last index of the grid edge in use
    always_comb begin
        if (r_grid_size == '0) begin
            n_last = '0;
        end else if (32'(r_grid_size) > 32'(gpmtz_pkg::MAX_SIZE)) begin
            n_last = gpmtz_pkg::CNT_W'(gpmtz_pkg::MAX_SIZE - 1);
        end else begin
            n_last = gpmtz_pkg::CNT_W'(r_grid_size - gpmtz_pkg::CFG_W'(1));
        end
    end

    assign last_col = (r_col == n_last);
    assign is_last  = last_col && (r_row == n_last);
    assign in_acc   = i_in.valid && i_in.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gpmtz_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.cell_value != '0) ? gpmtz_pkg::ST_TWOS
                                                      : gpmtz_pkg::ST_UPDATE;
                end
            end
            gpmtz_pkg::ST_TWOS: begin
                if (f_stat.done) n_state = gpmtz_pkg::ST_FIVES;
            end
            gpmtz_pkg::ST_FIVES: begin
                if (f_stat.done) n_state = gpmtz_pkg::ST_UPDATE;
            end
            gpmtz_pkg::ST_UPDATE: begin
                if (upd_go) n_state = gpmtz_pkg::ST_IDLE;
            end
            default: n_state = gpmtz_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_in.ready = 1'b0;
        f_cmd      = '{start: 1'b0, mode: gpmtz_pkg::FM_TWO};
        ram_re     = 1'b0;
        upd_go     = 1'b0;
        unique case (r_state)
            gpmtz_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                ram_re     = i_in.valid;
                f_cmd      = '{start: i_in.valid && (i_in.cell_value != '0),
                               mode: gpmtz_pkg::FM_TWO};
            end
            gpmtz_pkg::ST_TWOS: begin
                f_cmd = '{start: f_stat.done, mode: gpmtz_pkg::FM_FIVE};
            end
            gpmtz_pkg::ST_FIVES: begin
            end
            gpmtz_pkg::ST_UPDATE: begin
                // a result word waits for a still-full output register
                upd_go = !(is_last && r_out_valid && !o_out.ready);
            end
            default: begin
            end
        endcase
    end

    // Shared factor unit
    gpmtz_factor u_factor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (f_cmd),
        .i_value (in_acc ? i_in.cell_value : r_value),
        .o_stat  (f_stat)
    );

    // Row buffer: {fives, twos} per column
    gpmtz_ram #(
        .WIDTH (gpmtz_pkg::RAM_W),
        .DEPTH (gpmtz_pkg::MAX_SIZE)
    ) u_row_buf (
        .i_clk   (i_clk),
        .i_we    (upd_go),
        .i_waddr (r_col),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // Best sums reaching this cell
    always_comb begin
        own2 = gpmtz_pkg::SUM_W'(r_own2);
        own5 = gpmtz_pkg::SUM_W'(r_own5);
        u2   = (r_row != '0) ? ram_rdata[gpmtz_pkg::SUM_W-1:0] : gpmtz_pkg::UNREACH;
        u5   = (r_row != '0) ? ram_rdata[gpmtz_pkg::RAM_W-1:gpmtz_pkg::SUM_W]
                             : gpmtz_pkg::UNREACH;
        b2   = min16(u2, r_left2);
        b5   = min16(u5, r_left5);
        s2   = {1'b0, b2} + {1'b0, own2};
        s5   = {1'b0, b5} + {1'b0, own5};
        if (r_value == '0) begin
            t2 = gpmtz_pkg::UNREACH;
            t5 = gpmtz_pkg::UNREACH;
        end else if (r_row == '0 && r_col == '0) begin
            t2 = own2;
            t5 = own5;
        end else if (b2 != gpmtz_pkg::UNREACH && b5 != gpmtz_pkg::UNREACH) begin
            t2 = (s2 > {1'b0, gpmtz_pkg::SUM_MAX}) ? gpmtz_pkg::SUM_MAX
                                                   : s2[gpmtz_pkg::SUM_W-1:0];
            t5 = (s5 > {1'b0, gpmtz_pkg::SUM_MAX}) ? gpmtz_pkg::SUM_MAX
                                                   : s5[gpmtz_pkg::SUM_W-1:0];
        end else begin
            t2 = gpmtz_pkg::UNREACH;
            t5 = gpmtz_pkg::UNREACH;
        end
    end

    assign ram_wdata = {t5, t2};

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpmtz_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Grid position, left sums and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= gpmtz_pkg::CFG_W'(1);
            r_row       <= '0;
            r_col       <= '0;
            r_left2     <= gpmtz_pkg::UNREACH;
            r_left5     <= gpmtz_pkg::UNREACH;
        end else if (i_cfg_we) begin
            r_grid_size <= i_cfg_data;
            r_row       <= '0;
            r_col       <= '0;
            r_left2     <= gpmtz_pkg::UNREACH;
            r_left5     <= gpmtz_pkg::UNREACH;
        end else if (upd_go) begin
            if (last_col) begin
                r_col   <= '0;
                r_left2 <= gpmtz_pkg::UNREACH;
                r_left5 <= gpmtz_pkg::UNREACH;
                r_row   <= is_last ? '0 : r_row + gpmtz_pkg::CNT_W'(1);
            end else begin
                r_col   <= r_col + gpmtz_pkg::CNT_W'(1);
                r_left2 <= t2;
                r_left5 <= t5;
            end
        end
    end

    // Cell word and factor counts
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_value <= i_in.cell_value;
        end
        if (r_state == gpmtz_pkg::ST_TWOS && f_stat.done) begin
            r_own2 <= f_stat.count;
        end
        if (r_state == gpmtz_pkg::ST_FIVES && f_stat.done) begin
            r_own5 <= f_stat.count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go && is_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go && is_last) begin
            if (t2 == gpmtz_pkg::UNREACH || t5 == gpmtz_pkg::UNREACH) begin
                r_min_zeros <= '0;
                r_no_path   <= 1'b1;
            end else begin
                r_min_zeros <= min16(t2, t5);
                r_no_path   <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.min_zeros = r_min_zeros;
    assign o_out.no_path   = r_no_path;

    // Factor unit reports only while the sequencer waits for it
    a_done_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_stat.done |-> (r_state == gpmtz_pkg::ST_TWOS || r_state == gpmtz_pkg::ST_FIVES))
        else $error("factor unit done outside a counting state");

    // A nonzero cell always goes through factor counting
    a_nonzero_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.cell_value != '0) |=> (r_state == gpmtz_pkg::ST_TWOS))
        else $error("nonzero cell skipped factor counting");

    // Row and column position stay inside the grid in use
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= n_last) && (r_row <= n_last))
        else $error("grid position beyond grid size");

    // A blocked grid reports zero
    a_no_path_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_no_path) |-> (r_min_zeros == '0))
        else $error("no_path result with nonzero count");

    // A full output register is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_go && is_last) |-> (!r_out_valid || o_out.ready))
        else $error("result word overwritten");

endmodule
